[rtl/shuffle_order_generator_core_macros.svh]
// Assertion macros shared by the shuffle order generator RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SHUFFLE_ORDER_GENERATOR_CORE_MACROS_SVH
`define SHUFFLE_ORDER_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sog_pkg.sv]
// Shared types and constants of the shuffle order generator.
// No dependencies; used by the controller, datapath and top level.
package sog_pkg;

    localparam int LIST_MAX_DEFAULT = 256;
    localparam int RAND_BITS        = 32;
    localparam int RAND_W           = 32;
    localparam int INDEX_W          = 8;
    localparam int MODE_W           = 3;
    localparam int SIZE_W           = 9;
    localparam int CFG_IDX_W        = 1;

    localparam logic [MODE_W-1:0] MODE_ORDERED     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLIC      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM_ONCE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REPLAY      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REGEN       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_FIN
    } state_t;

    // Kind of work the current item needs, decided from the stored state.
    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_DRAW,
        OP_REPLAY
    } op_t;

    typedef enum logic [1:0] {
        RA_POS,
        RA_LAST,
        RA_REPLAY
    } raddr_sel_t;

    typedef struct packed {
        logic       load_rand;
        logic       calc_pos;
        raddr_sel_t raddr_sel;
        logic       cap_val;
        logic       wr_a;
        logic       wr_b;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        op_t op;
    } dp_status_t;

endpackage

[rtl/sog_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sog_ctrl.sv]
// Controller of the shuffle order generator: sequences one item at a time.
// Depends on sog_pkg; drives the datapath commands and the channel handshakes.
module sog_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  sog_pkg::dp_status_t status,
    output sog_pkg::dp_cmd_t    cmd
);
    import sog_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (status.op)
                        OP_DRAW:   state_next = ST_MUL;
                        OP_REPLAY: state_next = ST_RD_A;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_MUL:  state_next = ST_RD_A;
            ST_RD_A: state_next = ST_RD_B;
            ST_RD_B: state_next = (status.op == OP_DRAW) ? ST_WR_A : ST_FIN;
            ST_WR_A: state_next = ST_WR_B;
            ST_WR_B: state_next = ST_FIN;
            ST_FIN:  state_next = slot_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.raddr_sel = RA_POS;
        unique case (state_reg)
            ST_IDLE: cmd.load_rand = accept;
            ST_MUL:  cmd.calc_pos  = 1'b1;
            ST_RD_A: cmd.raddr_sel = (status.op == OP_DRAW) ? RA_POS : RA_REPLAY;
            ST_RD_B:
            begin
                cmd.cap_val   = 1'b1;
                cmd.raddr_sel = RA_LAST;
            end
            ST_WR_A: cmd.wr_a   = 1'b1;
            ST_WR_B: cmd.wr_b   = 1'b1;
            ST_FIN:  cmd.finish = slot_free;
            default: cmd.finish = 1'b0;
        endcase
    end

    // A finished item loads the output register even while the old one is taken.
    assign out_valid_next = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/sog_datapath.sv]
// Datapath of the shuffle order generator: config, counters, pool RAM, result register.
// Depends on sog_pkg and sog_ram; driven by commands from sog_ctrl.
module sog_datapath #(
    parameter int LIST_MAX = sog_pkg::LIST_MAX_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sog_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sog_pkg::SIZE_W-1:0]      cfg_data,
    input  logic [sog_pkg::RAND_W-1:0]      rand_value,
    input  sog_pkg::dp_cmd_t                cmd,
    output sog_pkg::dp_status_t             status,
    output logic [sog_pkg::INDEX_W-1:0]     index,
    output logic                            has_more,
    output logic                            exhausted
);
    import sog_pkg::*;

    localparam int AW = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
    localparam int CW = $clog2(LIST_MAX + 1);
    localparam int PW = RAND_W + CW;
    localparam logic [RAND_W-1:0] RAND_MASK = (RAND_BITS >= RAND_W) ? {RAND_W{1'b1}} :
                                              RAND_W'((64'd1 << RAND_BITS) - 64'd1);
    localparam logic [CW-1:0] N_MAX = CW'(LIST_MAX);

    // Control state
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CW-1:0]       size_reg, size_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic                phase_reg, phase_next;
    logic [LIST_MAX-1:0] valid_reg, valid_next;

    // Payload
    logic [RAND_W-1:0]   rand_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       val_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                has_more_reg;
    logic                exhausted_reg;

    logic [CW-1:0]       rem_eff;
    logic [CW-1:0]       last_c;
    logic [AW-1:0]       last_a;
    logic [AW-1:0]       cur_eff;
    logic [CW-1:0]       cur_inc;
    logic [AW-1:0]       cur_next;
    logic [AW-1:0]       replay_addr;
    logic [PW-1:0]       prod;
    logic [PW-1:0]       scaled;
    logic [AW-1:0]       pos_c;
    logic [CW-1:0]       size_c;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       wdata;
    logic                ram_we;
    logic [AW-1:0]       rdata;
    logic [AW-1:0]       rd_eff;
    logic [AW-1:0]       idx_c;
    logic                more_c;
    logic                exh_c;

    // In regenerate mode an empty pool counts as full.
    assign rem_eff = (mode_reg == MODE_REGEN && rem_reg == '0) ? size_reg : rem_reg;
    assign last_c  = rem_eff - CW'(1);
    assign last_a  = AW'(last_c);

    assign cur_eff     = (CW'(cursor_reg) >= size_reg) ? '0 : cursor_reg;
    assign cur_inc     = CW'(cur_eff) + CW'(1);
    assign cur_next    = (cur_inc == size_reg) ? '0 : AW'(cur_inc);
    assign replay_addr = AW'(size_reg - CW'(1) - CW'(cur_eff));

    assign prod   = PW'(rand_reg & RAND_MASK) * PW'(rem_eff);
    assign scaled = prod >> RAND_BITS;
    assign pos_c  = (scaled >= PW'(rem_eff)) ? last_a : AW'(scaled);

    always_comb
    begin
        unique case (mode_reg)
            MODE_RANDOM_ONCE: status.op = (rem_reg == '0) ? OP_DIRECT : OP_DRAW;
            MODE_REPLAY:      status.op = (!phase_reg && rem_reg != '0) ? OP_DRAW : OP_REPLAY;
            MODE_REGEN:       status.op = OP_DRAW;
            default:          status.op = OP_DIRECT;
        endcase
    end

    always_comb
    begin
        unique case (cmd.raddr_sel)
            RA_POS:    raddr = pos_reg;
            RA_LAST:   raddr = last_a;
            RA_REPLAY: raddr = replay_addr;
            default:   raddr = pos_reg;
        endcase
    end

    // An entry never written since the last reinit holds its own address.
    assign rd_eff = valid_reg[rd_addr_reg] ? rdata : rd_addr_reg;

    assign ram_we = cmd.wr_a || cmd.wr_b;
    assign waddr  = cmd.wr_a ? pos_reg : last_a;
    assign wdata  = cmd.wr_a ? rd_eff : val_reg;

    sog_ram #(
        .WIDTH (AW),
        .DEPTH (LIST_MAX)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (cfg_data == '0)
        begin
            size_c = CW'(1);
        end
        else if (32'(cfg_data) > LIST_MAX)
        begin
            size_c = N_MAX;
        end
        else
        begin
            size_c = CW'(cfg_data);
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        size_next   = size_reg;
        rem_next    = rem_reg;
        cursor_next = cursor_reg;
        phase_next  = phase_reg;
        valid_next  = valid_reg;
        idx_c       = '0;
        more_c      = 1'b0;
        exh_c       = 1'b0;

        if (cmd.wr_a)
        begin
            valid_next[pos_reg] = 1'b1;
        end
        if (cmd.wr_b)
        begin
            valid_next[last_a] = 1'b1;
        end

        if (cmd.finish)
        begin
            unique case (mode_reg)
                MODE_CYCLIC:
                begin
                    idx_c       = cur_eff;
                    cursor_next = cur_next;
                    more_c      = 1'b1;
                end
                MODE_RANDOM_ONCE:
                begin
                    if (rem_reg == '0)
                    begin
                        exh_c = 1'b1;
                    end
                    else
                    begin
                        idx_c    = val_reg;
                        rem_next = last_c;
                        more_c   = (last_c != '0);
                    end
                end
                MODE_REPLAY:
                begin
                    more_c = 1'b1;
                    idx_c  = val_reg;
                    if (!phase_reg && rem_reg != '0)
                    begin
                        rem_next = last_c;
                        if (last_c == '0)
                        begin
                            phase_next  = 1'b1;
                            cursor_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next  = 1'b1;
                        cursor_next = cur_next;
                    end
                end
                MODE_REGEN:
                begin
                    idx_c  = val_reg;
                    more_c = 1'b1;
                    if (last_c == '0)
                    begin
                        rem_next   = size_reg;
                        valid_next = '0;
                    end
                    else
                    begin
                        rem_next = last_c;
                    end
                end
                default:
                begin
                    if (rem_reg == '0)
                    begin
                        exh_c = 1'b1;
                    end
                    else
                    begin
                        idx_c    = AW'(size_reg - rem_reg);
                        rem_next = last_c;
                        more_c   = (last_c != '0);
                    end
                end
            endcase
        end

        // Any register write restarts the list from the identity order.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                    rem_next  = size_reg;
                end
                REG_LIST_SIZE:
                begin
                    size_next = size_c;
                    rem_next  = size_c;
                end
                default:
                begin
                    rem_next = size_reg;
                end
            endcase
            cursor_next = '0;
            phase_next  = 1'b0;
            valid_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ORDERED;
            size_reg   <= CW'(1);
            rem_reg    <= CW'(1);
            cursor_reg <= '0;
            phase_reg  <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            size_reg   <= size_next;
            rem_reg    <= rem_next;
            cursor_reg <= cursor_next;
            phase_reg  <= phase_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= raddr;
        if (cmd.load_rand)
        begin
            rand_reg <= rand_value;
        end
        if (cmd.calc_pos)
        begin
            pos_reg <= pos_c;
        end
        if (cmd.cap_val)
        begin
            val_reg <= rd_eff;
        end
        if (cmd.finish)
        begin
            index_reg     <= INDEX_W'(idx_c);
            has_more_reg  <= more_c;
            exhausted_reg <= exh_c;
        end
    end

    assign index     = index_reg;
    assign has_more  = has_more_reg;
    assign exhausted = exhausted_reg;

endmodule

[rtl/shuffle_order_generator_core.sv]
// Ordered, cyclic and exhausted requests go from accept straight to the result;
// a replay read takes two pool reads; a random draw a multiply, two pool reads,
// two pool writes through the single write port of the pool RAM, then the result.
// One item at a time: a new request is taken only once the last result is loaded.
// Reset (async, active low): mode ordered, list size 1, pool reads as identity
// through per-entry valid flags, so no clearing pass is needed.
`include "shuffle_order_generator_core_macros.svh"

module shuffle_order_generator_core #(
    parameter int LIST_MAX = sog_pkg::LIST_MAX_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sog_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sog_pkg::SIZE_W-1:0]      cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [sog_pkg::RAND_W-1:0]      rand_value,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [sog_pkg::INDEX_W-1:0]     index,
    output logic                            has_more,
    output logic                            exhausted
);
    import sog_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    sog_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    sog_datapath #(
        .LIST_MAX (LIST_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rand_value (rand_value),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .index      (index),
        .has_more   (has_more),
        .exhausted  (exhausted)
    );

    `SOG_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "item accepted but block still ready")
    `SOG_ASSERT_NOW(a_exhausted_clean, rsp_valid && exhausted, !has_more && index == '0, "exhausted item carries data")
    `SOG_ASSERT_NEXT(a_swap_completes, dp_cmd.wr_a, dp_cmd.wr_b, "pool swap left half done")

endmodule

[test/testbench.sv]
// Self-checking testbench for shuffle_order_generator_core: ordered, cyclic,
// random once, replay and regenerate draws checked against an in-bench predictor.
// Depends on sog_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module testbench;
    import sog_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TARGET_ITEMS = 1120;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               has_more;
        logic               exhausted;
    } pick_t;

    // Tracks the generator's pool and cursor and holds the picks still owed.
    class pick_tracker;
        logic [MODE_W-1:0]  mode;
        logic [SIZE_W-1:0]  list_size;
        logic [INDEX_W-1:0] pool_order [LIST_MAX_DEFAULT];
        int unsigned        remaining;
        int unsigned        cursor;
        bit                 replaying;
        pick_t              expected_picks [$];
        int                 failures;

        function new();
            mode = MODE_ORDERED;
            list_size = 9'd1;
            failures = 0;
            restart();
        endfunction

        function int unsigned span();
            if (list_size == 0)
                return 1;
            if (list_size > LIST_MAX_DEFAULT)
                return LIST_MAX_DEFAULT;
            return int'(list_size);
        endfunction

        function void restart();
            for (int i = 0; i < LIST_MAX_DEFAULT; i++)
                pool_order[i] = INDEX_W'(i);
            remaining = span();
            cursor = 0;
            replaying = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
            if (idx == REG_MODE)
                mode = value[MODE_W-1:0];
            else
                list_size = value;
            restart();
        endfunction

        // Swap-remove: the drawn entry moves to the top of the live pool.
        function logic [INDEX_W-1:0] take_from_pool(logic [RAND_W-1:0] r);
            longint unsigned    product;
            int unsigned        pos;
            int unsigned        last;
            logic [INDEX_W-1:0] val;
            product = 64'(r) * 64'(remaining);
            pos = int'(product >> RAND_BITS);
            if (pos >= remaining)
                pos = remaining - 1;
            last = remaining - 1;
            val = pool_order[pos];
            pool_order[pos] = pool_order[last];
            pool_order[last] = val;
            remaining = last;
            return val;
        endfunction

        function void predict_pick(logic [RAND_W-1:0] r);
            pick_t       p;
            int unsigned n;
            p = '0;
            n = span();
            case (mode)
                MODE_CYCLIC:
                begin
                    if (cursor >= n)
                        cursor = 0;
                    p.index = INDEX_W'(cursor);
                    cursor = (cursor + 1) % n;
                    p.has_more = 1'b1;
                end
                MODE_RANDOM_ONCE:
                begin
                    if (remaining == 0)
                        p.exhausted = 1'b1;
                    else
                    begin
                        p.index = take_from_pool(r);
                        p.has_more = (remaining > 0);
                    end
                end
                MODE_REPLAY:
                begin
                    if (!replaying && remaining > 0)
                    begin
                        p.index = take_from_pool(r);
                        if (remaining == 0)
                        begin
                            replaying = 1'b1;
                            cursor = 0;
                        end
                    end
                    else
                    begin
                        // Drawn entries sit at the top in reverse order, so read downward.
                        replaying = 1'b1;
                        if (cursor >= n)
                            cursor = 0;
                        p.index = pool_order[n - 1 - cursor];
                        cursor = (cursor + 1) % n;
                    end
                    p.has_more = 1'b1;
                end
                MODE_REGEN:
                begin
                    if (remaining == 0)
                        remaining = n;
                    p.index = take_from_pool(r);
                    if (remaining == 0)
                    begin
                        for (int i = 0; i < n; i++)
                            pool_order[i] = INDEX_W'(i);
                        remaining = n;
                    end
                    p.has_more = 1'b1;
                end
                default:
                begin
                    if (remaining == 0)
                        p.exhausted = 1'b1;
                    else
                    begin
                        p.index = INDEX_W'(n - remaining);
                        remaining--;
                        p.has_more = (remaining > 0);
                    end
                end
            endcase
            expected_picks.push_back(p);
        endfunction

        function void check_pick(logic [INDEX_W-1:0] index, logic more, logic exh);
            pick_t want;
            if (expected_picks.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result index %0d has_more %0b exhausted %0b",
                             index, more, exh);
                return;
            end
            want = expected_picks.pop_front();
            if ({index, more, exh} !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: expected index %0d has_more %0b exhausted %0b, got %0d %0b %0b",
                             want.index, want.has_more, want.exhausted, index, more, exh);
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
    logic [SIZE_W-1:0]     cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [RAND_W-1:0]     rand_value = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [INDEX_W-1:0]    index;
    logic                  has_more;
    logic                  exhausted;

    pick_tracker tracker = new();
    bit          quiet = 1'b0;
    int          items_sent = 0;
    int          cycle_count = 0;

    shuffle_order_generator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .rand_value (rand_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .index      (index),
        .has_more   (has_more),
        .exhausted  (exhausted)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        tracker.write_register(idx, value);
    endtask

    // A zero gap keeps valid high straight into the next item.
    task automatic send_request(input logic [RAND_W-1:0] r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        rand_value <= r;
        @(posedge clk);
        while (req_ready !== 1'b1)
            @(posedge clk);
        tracker.predict_pick(r);
        items_sent++;
    endtask

    // A negative count lets the phase length follow the mode and size just written.
    task automatic run_phase(input bit wr_mode, input logic [MODE_W-1:0] m, input bit wr_size,
                             input logic [SIZE_W-1:0] s, input int count, input bit directed);
        int          n;
        int          items;
        logic [RAND_W-1:0] r;
        while (tracker.pending() != 0)
            @(posedge clk);
        if (wr_mode)
            write_register(REG_MODE, {6'($urandom_range(0, 63)), m});
        if (wr_size)
            write_register(REG_LIST_SIZE, s);
        cfg_we <= 1'b0;
        quiet = ($urandom_range(0, 5) == 0);
        items = count;
        n = int'(tracker.span());
        if (items < 0)
        begin
            case (tracker.mode)
                MODE_CYCLIC, MODE_REGEN: items = $urandom_range(1, 2 * n + 2);
                MODE_REPLAY:             items = n + $urandom_range(1, n + 2);
                default:                 items = n + $urandom_range(0, 3);
            endcase
            // The last phase stops at the item budget.
            if (items > TARGET_ITEMS - items_sent)
                items = TARGET_ITEMS - items_sent;
        end
        for (int i = 0; i < items; i++)
        begin
            if (directed)
                r = (i % 3 == 0) ? '0 : (i % 3 == 1) ? '1 : $urandom;
            else
                r = $urandom;
            send_request(r);
        end
        req_valid <= 1'b0;
    endtask

    initial
    begin : response_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (rsp_valid !== 1'b1)
                @(posedge clk);
            tracker.check_pick(index, has_more, exhausted);
        end
    end

    initial
    begin : stimulus
        int               wr_pick;
        int               size_pick;
        logic [MODE_W-1:0] m;
        logic [SIZE_W-1:0] s;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: one entry, then past the end.
        run_phase(1'b0, MODE_ORDERED, 1'b0, 9'd1, 2, 1'b1);
        run_phase(1'b1, MODE_ORDERED, 1'b1, 9'd3, 4, 1'b1);
        run_phase(1'b1, MODE_CYCLIC, 1'b1, 9'd2, 3, 1'b1);
        run_phase(1'b1, MODE_RANDOM_ONCE, 1'b1, 9'd3, 4, 1'b1);
        run_phase(1'b1, MODE_REPLAY, 1'b1, 9'd2, 4, 1'b1);
        run_phase(1'b1, MODE_REGEN, 1'b1, 9'd2, 3, 1'b1);
        // Unknown mode with a zero size behaves as ordered once over one entry.
        run_phase(1'b1, 3'd7, 1'b1, 9'd0, 2, 1'b1);

        while (items_sent < TARGET_ITEMS)
        begin
            wr_pick = $urandom_range(0, 3);
            m = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(5, 7))
                                            : MODE_W'($urandom_range(0, 4));
            size_pick = $urandom_range(0, 11);
            if (size_pick == 0)
                s = 9'd256;
            else if (size_pick == 1)
                s = SIZE_W'($urandom_range(257, 511));
            else if (size_pick == 2)
                s = 9'd0;
            else
                s = SIZE_W'($urandom_range(1, 16));
            run_phase(wr_pick != 1, m, wr_pick != 0, s, -1, 1'b0);
        end

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (tracker.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
